/* hw/rtl/bctd_pkg.sv */
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types and constants for the block cache tag and dirty manager.
// ----------------------------------------------------------------------------
`default_nettype none

package bctd_pkg;

  // Default sizes
  localparam int CAPACITY_DEF       = 8;
  localparam int BLOCKS_IN_PAGE_DEF = 8;

  // Fixed field widths
  localparam int LBA_W   = 32;
  localparam int SLOT_FW = 3;
  localparam int OFF_FW  = 3;
  localparam int CNT_W   = 32;
  localparam int PAGES_W = 4;
  localparam int DIRTY_W = 7;

  // Request modes (code 3 is undefined and dropped)
  localparam logic [1:0] MODE_GET  = 2'd0;
  localparam logic [1:0] MODE_MARK = 2'd1;
  localparam logic [1:0] MODE_SYNC = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_HIT       = 3'd0,
    STAT_MISS      = 3'd1,
    STAT_NO_CARD   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_MARKED    = 3'd4,
    STAT_IGNORED   = 3'd5,
    STAT_WRITEBACK = 3'd6,
    STAT_SYNC_NONE = 3'd7
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFSET,
    S_SCAN,
    S_SYNC,
    S_EMIT
  } state_t;

  // Write controls for the tag file
  typedef struct packed {
    logic               tag_we;     // write tag, clear the row's dirty mask
    logic               bit_set;    // set one dirty bit
    logic               clear_all;  // clear every dirty mask
    logic [SLOT_FW-1:0] addr;
    logic [OFF_FW-1:0]  bit_idx;
  } tf_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/block_cache_tag_dirty_manager.sv */
// ----------------------------------------------------------------------------
// block_cache_tag_dirty_manager
// Fully associative tag and dirty-bit manager for a write-back block cache.
// ----------------------------------------------------------------------------
// One request at a time. A get or mark is taken in the idle state, passes the
// offset unit (a mask when BLOCKS_IN_PAGE is a power of two, else one nibble
// of lba per cycle), then the held slots are compared in turn by the single
// tag comparator until the hit or the end of the table, then the result beat,
// held until taken; a get with no card skips the compare. A sync is taken in
// the idle state, then walks the block positions, newest slot first, up to
// the last dirty block, with one result beat per write-back; with nothing
// dirty it gives one beat. Statistics on every beat show the state after
// the whole request. s_tready is high only while no request is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module block_cache_tag_dirty_manager #(
  parameter int CAPACITY       = bctd_pkg::CAPACITY_DEF,
  parameter int BLOCKS_IN_PAGE = bctd_pkg::BLOCKS_IN_PAGE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // Request stream
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [39:0]   s_tdata,   // lba[31:0], card_present[32], zero pad
  input  wire logic [1:0]    s_tuser,   // mode[1:0]
  // Result stream
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [119:0]       m_tdata,   // slot[2:0], block_offset[5:3],
                                        // block_number[37:6], written_count[44:38],
                                        // hit_count[76:45], miss_count[108:77],
                                        // pages_held[112:109],
                                        // dirty_blocks_held[119:113]
  output logic [2:0]         m_tuser,   // status[2:0]
  output logic               m_tlast    // is_last
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = (BLOCKS_IN_PAGE > 1) ? $clog2(BLOCKS_IN_PAGE) : 1;

  // Sequencer and request registers
  bctd_pkg::state_t                state, state_next;
  logic [1:0]                      mode_r;
  logic                            card_r;
  logic [bctd_pkg::LBA_W-1:0]      lba_r;
  logic [SW-1:0]                   idx;
  logic [OW-1:0]                   bpos;
  logic [bctd_pkg::DIRTY_W-1:0]    written;
  logic [bctd_pkg::DIRTY_W-1:0]    sync_total;

  // Cache state
  logic [bctd_pkg::PAGES_W-1:0]    slots_used;
  logic [bctd_pkg::CNT_W-1:0]      hit_total;
  logic [bctd_pkg::CNT_W-1:0]      miss_total;
  logic [bctd_pkg::DIRTY_W-1:0]    dirty_total;

  // Result register
  bctd_pkg::status_t               o_status;
  logic [bctd_pkg::SLOT_FW-1:0]    o_slot;
  logic [bctd_pkg::OFF_FW-1:0]     o_off;
  logic [bctd_pkg::LBA_W-1:0]      o_blk;
  logic                            o_last;
  logic [bctd_pkg::DIRTY_W-1:0]    o_written;

  // Actions from the sequencer
  logic                            emit;
  bctd_pkg::status_t               e_status;
  logic [bctd_pkg::SLOT_FW-1:0]    e_slot;
  logic [bctd_pkg::OFF_FW-1:0]     e_off;
  logic [bctd_pkg::LBA_W-1:0]      e_blk;
  logic                            e_last;
  logic [bctd_pkg::DIRTY_W-1:0]    e_written;
  logic                            inc_hit, inc_miss, inc_dirty;
  logic                            sync_init, advance, scan_step, scan_load;
  logic                            off_start;
  bctd_pkg::tf_ctl_t               tf_ctl;

  logic                            acc_in, acc_out;
  logic                            u_done;
  logic [bctd_pkg::OFF_FW-1:0]     u_off;
  logic [bctd_pkg::LBA_W-1:0]      base;
  logic [bctd_pkg::LBA_W-1:0]      rtag;
  logic [BLOCKS_IN_PAGE-1:0]       rmask;
  logic                            hit_now, scan_end, wb_bit, mark_bit;

  assign acc_in   = s_tvalid && s_tready;
  assign acc_out  = m_tvalid && m_tready;
  assign s_tready = (state == bctd_pkg::S_IDLE);
  assign m_tvalid = (state == bctd_pkg::S_EMIT);

  // Offset unit
  bctd_offset_unit #(
    .BLOCKS_IN_PAGE (BLOCKS_IN_PAGE)
  ) u_offset (
    .clk   (clk),
    .rst   (rst),
    .start (off_start),
    .lba   (s_tdata[31:0]),
    .done  (u_done),
    .off   (u_off)
  );

  // Tag file
  bctd_tag_file #(
    .CAPACITY       (CAPACITY),
    .BLOCKS_IN_PAGE (BLOCKS_IN_PAGE)
  ) u_tags (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tf_ctl),
    .wtag  (base),
    .raddr (bctd_pkg::SLOT_FW'(idx)),
    .rtag  (rtag),
    .rmask (rmask)
  );

  // Shared compare: one slot per cycle
  assign base     = lba_r - bctd_pkg::LBA_W'(u_off);
  assign hit_now  = (slots_used != '0) && (rtag == base);
  assign scan_end = (slots_used == '0) ||
                    ((bctd_pkg::PAGES_W'(idx) + 4'd1) == slots_used);
  assign wb_bit   = rmask[bpos];
  assign mark_bit = rmask[u_off[OW-1:0]];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bctd_pkg::S_IDLE: begin
        if (acc_in) begin
          if (s_tuser == bctd_pkg::MODE_GET || s_tuser == bctd_pkg::MODE_MARK) begin
            state_next = bctd_pkg::S_OFFSET;
          end else if (s_tuser == bctd_pkg::MODE_SYNC) begin
            state_next = bctd_pkg::S_SYNC;
          end
        end
      end
      bctd_pkg::S_OFFSET: begin
        if (u_done) begin
          if (mode_r == bctd_pkg::MODE_GET && !card_r) begin
            state_next = bctd_pkg::S_EMIT;
          end else begin
            state_next = bctd_pkg::S_SCAN;
          end
        end
      end
      bctd_pkg::S_SCAN: begin
        if (hit_now || scan_end) begin
          state_next = bctd_pkg::S_EMIT;
        end
      end
      bctd_pkg::S_SYNC: begin
        if (sync_total == '0 || wb_bit) begin
          state_next = bctd_pkg::S_EMIT;
        end
      end
      bctd_pkg::S_EMIT: begin
        if (acc_out) begin
          if (mode_r == bctd_pkg::MODE_SYNC && !o_last) begin
            state_next = bctd_pkg::S_SYNC;
          end else begin
            state_next = bctd_pkg::S_IDLE;
          end
        end
      end
      default: state_next = bctd_pkg::S_IDLE;
    endcase
  end

  // Actions
  always_comb begin
    emit      = 1'b0;
    e_status  = bctd_pkg::STAT_HIT;
    e_slot    = '0;
    e_off     = u_off;
    e_blk     = '0;
    e_last    = 1'b1;
    e_written = '0;
    inc_hit   = 1'b0;
    inc_miss  = 1'b0;
    inc_dirty = 1'b0;
    sync_init = 1'b0;
    advance   = 1'b0;
    scan_step = 1'b0;
    scan_load = 1'b0;
    off_start = 1'b0;
    tf_ctl    = '0;
    case (state)
      bctd_pkg::S_IDLE: begin
        if (acc_in) begin
          off_start = (s_tuser == bctd_pkg::MODE_GET || s_tuser == bctd_pkg::MODE_MARK);
          sync_init = (s_tuser == bctd_pkg::MODE_SYNC);
        end
      end
      bctd_pkg::S_OFFSET: begin
        if (u_done) begin
          scan_load = 1'b1;
          if (mode_r == bctd_pkg::MODE_GET && !card_r) begin
            emit     = 1'b1;
            e_status = bctd_pkg::STAT_NO_CARD;
          end
        end
      end
      bctd_pkg::S_SCAN: begin
        if (hit_now) begin
          emit   = 1'b1;
          e_slot = bctd_pkg::SLOT_FW'(idx);
          if (mode_r == bctd_pkg::MODE_GET) begin
            e_status = bctd_pkg::STAT_HIT;
            inc_hit  = 1'b1;
          end else begin
            e_status       = bctd_pkg::STAT_MARKED;
            tf_ctl.bit_set = 1'b1;
            tf_ctl.addr    = bctd_pkg::SLOT_FW'(idx);
            tf_ctl.bit_idx = u_off;
            inc_dirty      = !mark_bit;
          end
        end else if (scan_end) begin
          emit = 1'b1;
          if (mode_r == bctd_pkg::MODE_MARK) begin
            e_status = bctd_pkg::STAT_IGNORED;
          end else if (slots_used >= bctd_pkg::PAGES_W'(CAPACITY)) begin
            e_status = bctd_pkg::STAT_FULL;
          end else begin
            e_status      = bctd_pkg::STAT_MISS;
            e_slot        = bctd_pkg::SLOT_FW'(slots_used);
            e_blk         = base;
            inc_miss      = 1'b1;
            tf_ctl.tag_we = 1'b1;
            tf_ctl.addr   = bctd_pkg::SLOT_FW'(slots_used);
          end
        end else begin
          scan_step = 1'b1;
        end
      end
      bctd_pkg::S_SYNC: begin
        if (sync_total == '0) begin
          emit     = 1'b1;
          e_status = bctd_pkg::STAT_SYNC_NONE;
          e_off    = '0;
        end else if (wb_bit) begin
          emit      = 1'b1;
          e_status  = bctd_pkg::STAT_WRITEBACK;
          e_slot    = bctd_pkg::SLOT_FW'(idx);
          e_off     = bctd_pkg::OFF_FW'(bpos);
          e_blk     = rtag + bctd_pkg::LBA_W'(bpos);
          e_written = written + 7'd1;
          e_last    = ((written + 7'd1) == sync_total);
        end else begin
          advance = 1'b1;
        end
      end
      bctd_pkg::S_EMIT: begin
        if (acc_out && mode_r == bctd_pkg::MODE_SYNC) begin
          if (o_last) begin
            tf_ctl.clear_all = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bctd_pkg::S_IDLE;
      slots_used  <= '0;
      hit_total   <= '0;
      miss_total  <= '0;
      dirty_total <= '0;
    end else begin
      state <= state_next;
      if (inc_hit) begin
        hit_total <= hit_total + 32'd1;
      end
      if (inc_miss) begin
        miss_total <= miss_total + 32'd1;
        slots_used <= slots_used + 4'd1;
      end
      if (sync_init) begin
        dirty_total <= '0;
      end else if (inc_dirty) begin
        dirty_total <= dirty_total + 7'd1;
      end
    end
  end

  // Request and walk registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      mode_r <= s_tuser;
      lba_r  <= s_tdata[31:0];
      card_r <= s_tdata[32];
    end
    if (sync_init) begin
      idx        <= SW'(slots_used - 4'd1);
      bpos       <= '0;
      written    <= '0;
      sync_total <= dirty_total;
    end else if (scan_load) begin
      idx <= '0;
    end else if (scan_step) begin
      idx <= idx + SW'(1);
    end else if (advance) begin
      if (bpos == OW'(BLOCKS_IN_PAGE - 1)) begin
        bpos <= '0;
        idx  <= idx - SW'(1);
      end else begin
        bpos <= bpos + OW'(1);
      end
    end
    if (emit && e_status == bctd_pkg::STAT_WRITEBACK) begin
      written <= e_written;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      o_status  <= e_status;
      o_slot    <= e_slot;
      o_off     <= e_off;
      o_blk     <= e_blk;
      o_last    <= e_last;
      o_written <= e_written;
    end
  end

  assign m_tuser = o_status;
  assign m_tlast = o_last;
  assign m_tdata = {dirty_total, slots_used, miss_total, hit_total,
                    o_written, o_blk, o_off, o_slot};

`ifndef SYNTHESIS
  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= bctd_pkg::PAGES_W'(CAPACITY))
    else $error("slots_used beyond capacity");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("request taken while a result is pending");

  a_miss_grows: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && m_tuser == bctd_pkg::STAT_MISS)
      |-> slots_used == $past(slots_used) + 4'd1)
    else $error("miss fill without a new slot");

  a_wb_dirty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == bctd_pkg::STAT_WRITEBACK) |-> dirty_total == '0)
    else $error("dirty count not cleared during sync");

  a_written_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bctd_pkg::S_SYNC) |-> (written < sync_total || sync_total == '0))
    else $error("sync walk past its last dirty block");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bctd_offset_unit.sv */
// ----------------------------------------------------------------------------
// bctd_offset_unit
// Block offset within a page: lba mod BLOCKS_IN_PAGE. A power-of-two page is
// a mask; any other size is reduced one nibble per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_offset_unit #(
  parameter int BLOCKS_IN_PAGE = bctd_pkg::BLOCKS_IN_PAGE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [bctd_pkg::LBA_W-1:0]   lba,
  output logic                              done,
  output logic [bctd_pkg::OFF_FW-1:0]       off
);

  localparam bit POW2 = (BLOCKS_IN_PAGE & (BLOCKS_IN_PAGE - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      // Power of two: the offset is the low bits
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          off <= bctd_pkg::OFF_FW'(lba & bctd_pkg::LBA_W'(BLOCKS_IN_PAGE - 1));
        end
      end
    end else begin : g_iter
      logic                         busy;
      logic [2:0]                   cnt;
      logic [bctd_pkg::LBA_W-1:0]   sh;
      logic [bctd_pkg::OFF_FW-1:0]  rem;

      // Reduce rem*16 + nibble (below 128) by compare and subtract
      function automatic logic [bctd_pkg::OFF_FW-1:0] mod_small(input logic [6:0] v);
        logic [9:0] acc;
        acc = {3'b000, v};
        for (int k = 6; k >= 0; k--) begin
          if (acc >= (10'(BLOCKS_IN_PAGE) << k)) begin
            acc = acc - (10'(BLOCKS_IN_PAGE) << k);
          end
        end
        return bctd_pkg::OFF_FW'(acc);
      endfunction

      // Control
      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            cnt  <= '0;
          end else if (busy) begin
            cnt <= cnt + 3'd1;
            if (cnt == 3'd7) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
      end

      // Datapath: one nibble a cycle
      always_ff @(posedge clk) begin
        if (start) begin
          sh  <= lba;
          rem <= '0;
        end else if (busy) begin
          rem <= mod_small({rem, sh[31:28]});
          sh  <= {sh[27:0], 4'b0000};
        end
      end

      assign off = rem;
    end
  endgenerate

endmodule

`default_nettype wire

/* hw/rtl/bctd_tag_file.sv */
// ----------------------------------------------------------------------------
// bctd_tag_file
// Page base tags and per-block dirty masks, one read port at a chosen slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_tag_file #(
  parameter int CAPACITY       = bctd_pkg::CAPACITY_DEF,
  parameter int BLOCKS_IN_PAGE = bctd_pkg::BLOCKS_IN_PAGE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bctd_pkg::tf_ctl_t             ctl,
  input  wire logic [bctd_pkg::LBA_W-1:0]    wtag,
  input  wire logic [bctd_pkg::SLOT_FW-1:0]  raddr,
  output logic [bctd_pkg::LBA_W-1:0]         rtag,
  output logic [BLOCKS_IN_PAGE-1:0]          rmask
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = (BLOCKS_IN_PAGE > 1) ? $clog2(BLOCKS_IN_PAGE) : 1;

  logic [bctd_pkg::LBA_W-1:0]  tags  [CAPACITY];
  logic [BLOCKS_IN_PAGE-1:0]   masks [CAPACITY];

  // Tags: written on a miss fill, no reset
  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tags[ctl.addr[SW-1:0]] <= wtag;
    end
  end

  // Dirty masks
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      for (int i = 0; i < CAPACITY; i++) begin
        masks[i] <= '0;
      end
    end else if (ctl.tag_we) begin
      masks[ctl.addr[SW-1:0]] <= '0;
    end else if (ctl.bit_set) begin
      masks[ctl.addr[SW-1:0]][ctl.bit_idx[OW-1:0]] <= 1'b1;
    end
  end

  assign rtag  = tags[raddr[SW-1:0]];
  assign rmask = masks[raddr[SW-1:0]];

endmodule

`default_nettype wire

/* verif/block_cache_tag_dirty_manager_tb.sv */
// ----------------------------------------------------------------------------
// block_cache_tag_dirty_manager_tb
// Self-checking bench for the block cache tag and dirty-bit manager.
// ----------------------------------------------------------------------------
// A queue of requests (directed corner cases, then random gets, marks and
// syncs over a pool of page bases) feeds a stream driver. Each accepted
// request runs through a local tag/dirty model that queues the result beats
// it must produce. The monitor checks every result beat field by field
// against the oldest queued beat. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module block_cache_tag_dirty_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PAGE_SLOTS     = 8;
  localparam int          PAGE_BLOCKS    = 8;
  localparam int          RANDOM_ITEMS   = 330;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam logic [1:0]  MODE_UNDEF     = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] lba;
    logic        card;
    bit          drain;   // hold off until every pending beat has come back
  } cache_req_t;

  typedef struct packed {
    bctd_pkg::status_t status;
    logic [2:0]  slot;
    logic [2:0]  offset;
    logic [31:0] blk;
    logic        last;
    logic [6:0]  written;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [3:0]  pages;
    logic [6:0]  dirty;
  } cache_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;   // lba[31:0], card_present[32], zero pad
  logic [1:0]   s_tuser = '0;   // mode[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;        // slot, block_offset, block_number, written_count,
                                // hit_count, miss_count, pages_held,
                                // dirty_blocks_held
  logic [2:0]   m_tuser;        // status[2:0]
  logic         m_tlast;        // is_last

  block_cache_tag_dirty_manager dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Request queue and expected result beats
  cache_req_t  req_q[$];
  cache_beat_t wb_expect_q[$];
  int          launched_cnt = 0;
  int          taken_cnt    = 0;
  int          mismatches   = 0;
  int          quiet        = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;
  int          src_calm     = 0;
  int          sink_calm    = 0;

  // Tag file shadow
  logic [31:0] page_base [PAGE_SLOTS];
  logic [7:0]  dirty_bits [PAGE_SLOTS];
  int          slots_used = 0;
  logic [31:0] hit_total  = '0;
  logic [31:0] miss_total = '0;
  int          dirty_cnt  = 0;

  // Page bases the stimulus revisits
  logic [31:0] pool [PAGE_SLOTS];

  // Idle length: mostly short, a few long, with calm stretches of none
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_req(logic [1:0] mode, logic [31:0] lba, logic card,
                                  bit drain = 1'b0);
    cache_req_t r;
    r.mode  = mode;
    r.lba   = lba;
    r.card  = card;
    r.drain = drain;
    req_q.push_back(r);
  endfunction

  // Tag lookup, fill, dirty marking and write-back walk for one request
  function automatic void predict_request(logic [1:0] mode, logic [31:0] lba,
                                          logic card);
    cache_beat_t beats[$];
    cache_beat_t b;
    logic [31:0] base;
    int          hit_slot;
    int          s;
    int          i;
    int          wr;
    base     = {lba[31:3], 3'b000};
    b        = '0;
    b.offset = lba[2:0];
    b.last   = 1'b1;
    hit_slot = -1;
    for (s = 0; s < slots_used; s++)
      if (hit_slot < 0 && page_base[s] == base) hit_slot = s;
    case (mode)
      bctd_pkg::MODE_GET: begin
        if (!card) begin
          b.status = bctd_pkg::STAT_NO_CARD;
        end else if (hit_slot >= 0) begin
          hit_total++;
          b.status = bctd_pkg::STAT_HIT;
          b.slot   = hit_slot[2:0];
        end else if (slots_used >= PAGE_SLOTS) begin
          b.status = bctd_pkg::STAT_FULL;
        end else begin
          page_base[slots_used]  = base;
          dirty_bits[slots_used] = '0;
          b.status = bctd_pkg::STAT_MISS;
          b.slot   = slots_used[2:0];
          b.blk    = base;
          slots_used++;
          miss_total++;
        end
        beats.push_back(b);
      end
      bctd_pkg::MODE_MARK: begin
        if (hit_slot < 0) begin
          b.status = bctd_pkg::STAT_IGNORED;
        end else begin
          if (!dirty_bits[hit_slot][lba[2:0]]) begin
            dirty_bits[hit_slot][lba[2:0]] = 1'b1;
            dirty_cnt++;
          end
          b.status = bctd_pkg::STAT_MARKED;
          b.slot   = hit_slot[2:0];
        end
        beats.push_back(b);
      end
      bctd_pkg::MODE_SYNC: begin
        wr = 0;
        // newest slot first, ascending block order inside each page
        for (s = slots_used - 1; s >= 0; s--) begin
          for (i = 0; i < PAGE_BLOCKS; i++) begin
            if (dirty_bits[s][i]) begin
              wr++;
              b.status  = bctd_pkg::STAT_WRITEBACK;
              b.slot    = s[2:0];
              b.offset  = i[2:0];
              b.blk     = page_base[s] + 32'(i);
              b.last    = 1'b0;
              b.written = wr[6:0];
              beats.push_back(b);
            end
          end
          dirty_bits[s] = '0;
        end
        dirty_cnt = 0;
        if (beats.size() == 0) begin
          b.status = bctd_pkg::STAT_SYNC_NONE;
          b.offset = '0;
          beats.push_back(b);
        end else begin
          beats[beats.size() - 1].last = 1'b1;
        end
      end
      default: ;  // undefined mode: dropped, no beat
    endcase
    // statistics show the state after the whole request
    foreach (beats[k]) begin
      beats[k].hits   = hit_total;
      beats[k].misses = miss_total;
      beats[k].pages  = slots_used[3:0];
      beats[k].dirty  = dirty_cnt[6:0];
      wb_expect_q.push_back(beats[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: changes inputs at the falling edge
  always @(negedge clk) begin : drive_req
    cache_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || taken_cnt == launched_cnt) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0 &&
                   !(req_q[0].drain && wb_expect_q.size() != 0)) begin
        r = req_q.pop_front();
        s_tvalid     <= 1'b1;
        s_tuser      <= r.mode;
        s_tdata      <= {7'd0, r.card, r.lba};
        launched_cnt <= launched_cnt + 1;
        gap_left     <= idle_len(src_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_len(sink_calm);
    end
  end

  // Monitor: check result beats, then model newly accepted requests
  always @(posedge clk) begin : monitor
    cache_beat_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (wb_expect_q.size() == 0) begin
          $display("%0t: status expected no beat, got %0d", $time, m_tuser);
          mismatches++;
        end else begin
          want = wb_expect_q.pop_front();
          check_field("status",            32'(want.status),  32'(m_tuser));
          check_field("slot",              32'(want.slot),    32'(m_tdata[2:0]));
          check_field("block_offset",      32'(want.offset),  32'(m_tdata[5:3]));
          check_field("block_number",      want.blk,          m_tdata[37:6]);
          check_field("is_last",           32'(want.last),    32'(m_tlast));
          check_field("written_count",     32'(want.written), 32'(m_tdata[44:38]));
          check_field("hit_count",         want.hits,         m_tdata[76:45]);
          check_field("miss_count",        want.misses,       m_tdata[108:77]);
          check_field("pages_held",        32'(want.pages),   32'(m_tdata[112:109]));
          check_field("dirty_blocks_held", 32'(want.dirty),   32'(m_tdata[119:113]));
        end
      end
      if (s_tvalid && s_tready) begin
        predict_request(s_tuser, s_tdata[31:0], s_tdata[32]);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("block_cache_tag_dirty_manager: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int made;
    int pick;
    int ofs;
    int s;
    int o;
    bit flooded;
    logic [31:0] pg;

    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFF8;
    pool[2] = 32'hAAAA_AAA8;
    pool[3] = 32'h5555_5550;
    pool[4] = 32'h0000_0008;
    pool[5] = 32'h8000_0000;
    pool[6] = 32'h7FFF_FFF8;
    pool[7] = 32'h1234_5670;

    // Directed corner cases
    add_req(bctd_pkg::MODE_SYNC, 32'h0, 1'b1);                // nothing dirty
    add_req(bctd_pkg::MODE_MARK, 32'h0000_0003, 1'b1);        // page not held
    add_req(bctd_pkg::MODE_GET,  32'h0, 1'b0);                // no card
    add_req(bctd_pkg::MODE_GET,  32'h0000_0002, 1'b1);        // first fill
    add_req(bctd_pkg::MODE_GET,  32'h0000_0007, 1'b1);        // hit, top offset
    add_req(bctd_pkg::MODE_GET,  32'h0000_0003, 1'b0);        // no card on a held page
    add_req(bctd_pkg::MODE_MARK, 32'h0000_0005, 1'b1);
    add_req(bctd_pkg::MODE_MARK, 32'h0000_0005, 1'b1);        // already dirty
    add_req(MODE_UNDEF, 32'hFFFF_FFFF, 1'b1);                 // dropped
    add_req(bctd_pkg::MODE_GET,  32'hFFFF_FFFF, 1'b1);        // fill at top of space
    add_req(bctd_pkg::MODE_MARK, 32'hFFFF_FFFF, 1'b1);
    add_req(bctd_pkg::MODE_MARK, 32'hFFFF_FFF8, 1'b0);
    for (s = 2; s < PAGE_SLOTS; s++)
      add_req(bctd_pkg::MODE_GET, pool[s] + $urandom_range(0, 7), 1'b1);
    add_req(bctd_pkg::MODE_GET,  32'h0000_0010, 1'b1);        // table full
    add_req(bctd_pkg::MODE_MARK, 32'h0000_0010, 1'b1);
    add_req(bctd_pkg::MODE_SYNC, 32'hFFFF_FFFF, 1'b0);        // write-backs, newest first
    add_req(bctd_pkg::MODE_SYNC, 32'h0, 1'b1);                // nothing left dirty
    add_req(bctd_pkg::MODE_GET,  pool[7] + 1, 1'b1);
    add_req(bctd_pkg::MODE_MARK, pool[3] + 4, 1'b1);

    // Random traffic over the held pages, with some noise
    made    = 0;
    flooded = 1'b0;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      pg   = pool[$urandom_range(0, PAGE_SLOTS - 1)];
      ofs  = $urandom_range(0, 7);
      if (!flooded && made >= RANDOM_ITEMS / 2) begin
        // every block dirty, then one sync that writes them all back
        for (s = 0; s < PAGE_SLOTS; s++)
          for (o = 0; o < PAGE_BLOCKS; o++)
            add_req(bctd_pkg::MODE_MARK, pool[s] + 32'((o + ofs) % PAGE_BLOCKS), 1'b1);
        add_req(bctd_pkg::MODE_SYNC, $urandom(), 1'b1, 1'b1);
        made    += PAGE_SLOTS * PAGE_BLOCKS + 1;
        flooded  = 1'b1;
      end else if (pick < 3) begin
        add_req(MODE_UNDEF, $urandom(), 1'($urandom_range(0, 1)));
      end else begin
        if (pick < 30)      add_req(bctd_pkg::MODE_GET,  pg + 32'(ofs), 1'b1);
        else if (pick < 60) add_req(bctd_pkg::MODE_MARK, pg + 32'(ofs),
                                    1'($urandom_range(0, 1)));
        else if (pick < 71) add_req(bctd_pkg::MODE_SYNC, $urandom(),
                                    1'($urandom_range(0, 1)),
                                    $urandom_range(0, 9) == 0);
        else if (pick < 83) add_req(bctd_pkg::MODE_GET,  $urandom(),
                                    1'($urandom_range(0, 1)));
        else if (pick < 89) add_req(bctd_pkg::MODE_GET,  pg + 32'(ofs), 1'b0);
        else                add_req(bctd_pkg::MODE_MARK, $urandom(),
                                    1'($urandom_range(0, 1)));
        made++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || taken_cnt != launched_cnt) @(posedge clk);
    while (wb_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && wb_expect_q.size() == 0) begin
      $display("block_cache_tag_dirty_manager: match");
    end else begin
      $display("block_cache_tag_dirty_manager: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
